@@ src/tla_pkg.sv @@
// Shared types, constants and the octant arctangent table for the atan2 pipeline.
package tla_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int ANGLE_W    = 8;
    localparam int TBL_W      = 6;
    localparam int FRAC_BITS  = 8;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = FRAC_BITS / DIV_BITS;

    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 8'h40;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 8'h80;
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO    = 8'h40;
    localparam logic [Q_W-1:0]     Q_MAX         = 9'd256;

    typedef logic [COORD_BITS-1:0] mag_t;

    typedef struct packed {
        mag_t           rem;
        mag_t           den;
        logic [Q_W-1:0] quo;
        logic           swap;
        logic           xneg;
        logic           yneg;
        logic           zero;
    } tla_item_t;

    localparam logic [TBL_W-1:0] OCT_TBL [257] = '{
        6'h00, 6'h00, 6'h00, 6'h00, 6'h01, 6'h01, 6'h01, 6'h01,
        6'h01, 6'h01, 6'h02, 6'h02, 6'h02, 6'h02, 6'h02, 6'h02,
        6'h03, 6'h03, 6'h03, 6'h03, 6'h03, 6'h03, 6'h03, 6'h04,
        6'h04, 6'h04, 6'h04, 6'h04, 6'h04, 6'h05, 6'h05, 6'h05,
        6'h05, 6'h05, 6'h05, 6'h06, 6'h06, 6'h06, 6'h06, 6'h06,
        6'h06, 6'h06, 6'h07, 6'h07, 6'h07, 6'h07, 6'h07, 6'h07,
        6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h09,
        6'h09, 6'h09, 6'h09, 6'h09, 6'h09, 6'h0A, 6'h0A, 6'h0A,
        6'h0A, 6'h0A, 6'h0A, 6'h0A, 6'h0B, 6'h0B, 6'h0B, 6'h0B,
        6'h0B, 6'h0B, 6'h0B, 6'h0C, 6'h0C, 6'h0C, 6'h0C, 6'h0C,
        6'h0C, 6'h0C, 6'h0D, 6'h0D, 6'h0D, 6'h0D, 6'h0D, 6'h0D,
        6'h0D, 6'h0E, 6'h0E, 6'h0E, 6'h0E, 6'h0E, 6'h0E, 6'h0E,
        6'h0F, 6'h0F, 6'h0F, 6'h0F, 6'h0F, 6'h0F, 6'h0F, 6'h10,
        6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h11, 6'h11,
        6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h12, 6'h12,
        6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h13, 6'h13, 6'h13,
        6'h13, 6'h13, 6'h13, 6'h13, 6'h13, 6'h14, 6'h14, 6'h14,
        6'h14, 6'h14, 6'h14, 6'h14, 6'h14, 6'h15, 6'h15, 6'h15,
        6'h15, 6'h15, 6'h15, 6'h15, 6'h15, 6'h15, 6'h16, 6'h16,
        6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h17, 6'h17,
        6'h17, 6'h17, 6'h17, 6'h17, 6'h17, 6'h17, 6'h17, 6'h18,
        6'h18, 6'h18, 6'h18, 6'h18, 6'h18, 6'h18, 6'h18, 6'h18,
        6'h19, 6'h19, 6'h19, 6'h19, 6'h19, 6'h19, 6'h19, 6'h19,
        6'h19, 6'h19, 6'h1A, 6'h1A, 6'h1A, 6'h1A, 6'h1A, 6'h1A,
        6'h1A, 6'h1A, 6'h1A, 6'h1B, 6'h1B, 6'h1B, 6'h1B, 6'h1B,
        6'h1B, 6'h1B, 6'h1B, 6'h1B, 6'h1B, 6'h1C, 6'h1C, 6'h1C,
        6'h1C, 6'h1C, 6'h1C, 6'h1C, 6'h1C, 6'h1C, 6'h1C, 6'h1C,
        6'h1D, 6'h1D, 6'h1D, 6'h1D, 6'h1D, 6'h1D, 6'h1D, 6'h1D,
        6'h1D, 6'h1D, 6'h1D, 6'h1E, 6'h1E, 6'h1E, 6'h1E, 6'h1E,
        6'h1E, 6'h1E, 6'h1E, 6'h1E, 6'h1E, 6'h1E, 6'h1F, 6'h1F,
        6'h1F, 6'h1F, 6'h1F, 6'h1F, 6'h1F, 6'h1F, 6'h1F, 6'h1F,
        6'h1F, 6'h1F, 6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h20,
        6'h20
    };

endpackage

@@ src/table_atan2_byte_angle_top.sv @@
// Top level of the pipelined four-quadrant arctangent with byte-wide angle output.
//
// Takes a signed vector (x_coord, y_coord) and returns its direction as an
// 8-bit angle, 256 steps per turn; the zero vector gives 0x40. The smaller
// magnitude is scaled by 256 and divided by the larger in a restoring
// divider, the 9-bit quotient indexes a 257-entry octant table, and the
// octant angle is folded into the right quadrant. The pipeline takes one
// beat per clock while the output is not stalled. It has one front stage
// (magnitudes, octant swap), four divider stages of two quotient bits each,
// and one lookup/fold stage that also serves as the output register. Each
// stage holds its own valid bit and stalls only when it is full and the
// stage after it is stalled, so bubbles collapse and the input keeps taking
// beats while a result waits at the output, until every stage is full.
module table_atan2_byte_angle_top
    import tla_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [FIELD_W-1:0] x_coord,
    input  logic signed [FIELD_W-1:0] y_coord,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic        [ANGLE_W-1:0] angle
);

    // Stage links: index 0 is the front stage output, index DIV_STAGES the
    // last divider stage output.
    logic      link_valid [DIV_STAGES+1];
    logic      link_stall [DIV_STAGES+1];
    tla_item_t link_item  [DIV_STAGES+1];

    // Split signs, take magnitudes and order them for the divider.
    tla_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .dn_valid (link_valid[0]),
        .dn_stall (link_stall[0]),
        .dn_item  (link_item[0])
    );

    // Resolve the eight fractional quotient bits, two per stage.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        tla_div_stage u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_stall (link_stall[k]),
            .up_item  (link_item[k]),
            .dn_valid (link_valid[k+1]),
            .dn_stall (link_stall[k+1]),
            .dn_item  (link_item[k+1])
        );
    end

    // Look up the octant angle, fold it and hold it for the output beat.
    tla_fold u_fold
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[DIV_STAGES]),
        .up_stall (link_stall[DIV_STAGES]),
        .up_item  (link_item[DIV_STAGES]),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .angle    (angle)
    );

    // A stalled beat in the divider must stay in place, never vanish.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[DIV_STAGES] && link_stall[DIV_STAGES] |=> link_valid[DIV_STAGES])
        else $error("divider output beat dropped while stalled");

    // The partial remainder stays below the divisor for every nonzero vector.
    a_front_rem: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[0] && !link_item[0].zero |-> link_item[0].rem < link_item[0].den)
        else $error("front stage remainder not below divisor");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[DIV_STAGES] && !link_item[DIV_STAGES].zero
        |-> link_item[DIV_STAGES].rem < link_item[DIV_STAGES].den)
        else $error("divider remainder not below divisor");

    // The final quotient never runs past the last table entry.
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[DIV_STAGES] && !link_item[DIV_STAGES].zero
        |-> link_item[DIV_STAGES].quo <= Q_MAX)
        else $error("quotient beyond octant table");

endmodule

@@ src/tla_front.sv @@
// Input stage: sign/magnitude split, octant swap and first quotient bit.
module tla_front
    import tla_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_stall,
    input  logic signed [FIELD_W-1:0] x_coord,
    input  logic signed [FIELD_W-1:0] y_coord,
    output logic                      dn_valid,
    input  logic                      dn_stall,
    output tla_item_t                 dn_item
);

    logic      valid_reg;
    tla_item_t item_reg;
    tla_item_t item_next;
    mag_t      x_val;
    mag_t      y_val;
    mag_t      x_mag;
    mag_t      y_mag;
    logic      x_neg;
    logic      y_neg;
    logic      same_mag;

    always_comb
    begin
        x_val    = COORD_BITS'($unsigned(x_coord));
        y_val    = COORD_BITS'($unsigned(y_coord));
        x_neg    = x_val[COORD_BITS-1];
        y_neg    = y_val[COORD_BITS-1];
        x_mag    = x_neg ? (~x_val) + COORD_BITS'(1) : x_val;
        y_mag    = y_neg ? (~y_val) + COORD_BITS'(1) : y_val;
        same_mag = (x_mag == y_mag);

        item_next.swap = !(y_mag < x_mag);
        item_next.xneg = x_neg;
        item_next.yneg = y_neg;
        item_next.zero = (x_mag == '0) && (y_mag == '0);
        item_next.den  = item_next.swap ? y_mag : x_mag;
        // Equal magnitudes give the top quotient bit and a zero remainder.
        item_next.rem  = same_mag ? '0 : (item_next.swap ? x_mag : y_mag);
        item_next.quo  = Q_W'(same_mag);
    end

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ src/tla_div_stage.sv @@
// One restoring-divider stage: resolve DIV_BITS quotient bits.
module tla_div_stage
    import tla_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_stall,
    input  tla_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_stall,
    output tla_item_t dn_item
);

    logic                valid_reg;
    tla_item_t           item_reg;
    tla_item_t           item_next;
    logic [COORD_BITS:0] trial;
    mag_t                rem_work;
    logic [Q_W-1:0]      quo_work;

    always_comb
    begin
        item_next = up_item;
        rem_work  = up_item.rem;
        quo_work  = up_item.quo;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {rem_work, 1'b0};
            if (trial >= {1'b0, up_item.den})
            begin
                rem_work = COORD_BITS'(trial - {1'b0, up_item.den});
                quo_work = {quo_work[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_work = COORD_BITS'(trial);
                quo_work = {quo_work[Q_W-2:0], 1'b0};
            end
        end
        item_next.rem = rem_work;
        item_next.quo = quo_work;
    end

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ src/tla_fold.sv @@
// Output stage: octant table lookup and quadrant fold into the final angle.
module tla_fold
    import tla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_stall,
    input  tla_item_t          up_item,
    output logic               dn_valid,
    input  logic               dn_stall,
    output logic [ANGLE_W-1:0] angle
);

    logic               valid_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [ANGLE_W-1:0] angle_next;
    logic [ANGLE_W-1:0] oct_angle;
    logic [ANGLE_W-1:0] x_fold;
    logic [ANGLE_W-1:0] y_fold;

    always_comb
    begin
        oct_angle = ANGLE_W'(OCT_TBL[up_item.quo]);
        if (up_item.swap)
        begin
            oct_angle = ANGLE_QUARTER - oct_angle;
        end
        x_fold = up_item.xneg ? oct_angle : ANGLE_HALF - oct_angle;
        // Mirroring about the x axis is a negate modulo one turn.
        y_fold = up_item.yneg ? x_fold : ANGLE_W'(0) - x_fold;
        angle_next = up_item.zero ? ANGLE_ZERO : y_fold;
    end

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign angle    = angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            angle_reg <= angle_next;
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the byte-angle atan2 pipeline: directed corners, random vectors, idle bursts.
module tb_top
    import tla_pkg::*;
();

    // Clock period is 2 ns. The run aborts well past the slowest legal run:
    // about 950 beats, each with idle bursts on both sides, plus the
    // six-stage pipeline.
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 24;
    localparam int REPORT_MAX   = 10;

    // Angle constants, in 1/256 turn.
    localparam int ZERO_VEC_ANGLE = 'h40;
    localparam int QUARTER_TURN   = 'h40;
    localparam int HALF_TURN      = 'h80;
    localparam int FULL_TURN      = 'h100;

    // Octant arctangent as a step function. Entry k-1 holds the first scaled
    // quotient whose octant angle reaches k, so the angle for quotient q is
    // the number of entries that q has passed. It runs from 0 up to 0x20 at
    // q = 256.
    localparam int OCTANT_STEPS [32] = '{
          4,  10,  16,  23,  29,  35,  42,  48,
         55,  61,  68,  75,  82,  89,  96, 103,
        110, 118, 125, 133, 141, 150, 158, 167,
        176, 186, 195, 205, 216, 227, 238, 250
    };

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic                      out_valid;
    logic                      out_stall;
    logic        [ANGLE_W-1:0] angle;

    // Angles still owed by the pipeline, oldest first.
    logic [ANGLE_W-1:0] expected_angles [$];

    int fail_count;
    int cycle_count;
    // Odds of idling: 1 in N per input beat or per idle output edge, 0 turns that side's idling off.
    int gap_odds;
    int stall_odds;

    table_atan2_byte_angle_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle     (angle)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Watchdog: abort a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------

    // Octant angle for a scaled quotient in 0..256.
    function automatic int octant_angle(input int quot);
        int steps;
        steps = 0;
        foreach (OCTANT_STEPS[i])
        begin
            if (quot >= OCTANT_STEPS[i])
                steps++;
        end
        return steps;
    endfunction

    // Direction of (x, y) in 1/256 turn. Both components are full 16-bit
    // two's complement, so -32768 has magnitude 32768 and fits easily in an
    // int, as does the shifted magnitude.
    function automatic logic [ANGLE_W-1:0] predict_angle(
        input logic signed [FIELD_W-1:0] x,
        input logic signed [FIELD_W-1:0] y
    );
        int xs;
        int ys;
        int x_mag;
        int y_mag;
        int quot;
        int dir;
        logic [ANGLE_W-1:0] folded;
        xs    = x;
        ys    = y;
        x_mag = (xs < 0) ? -xs : xs;
        y_mag = (ys < 0) ? -ys : ys;
        if (x_mag == 0 && y_mag == 0)
            return ANGLE_W'(ZERO_VEC_ANGLE);
        // Divide the smaller magnitude by the larger; ties take the second
        // branch and land on quotient 256.
        if (y_mag < x_mag)
        begin
            quot = (y_mag * 256) / x_mag;
            dir  = octant_angle(quot > 256 ? 256 : quot);
        end
        else
        begin
            quot = (x_mag * 256) / y_mag;
            dir  = QUARTER_TURN - octant_angle(quot > 256 ? 256 : quot);
        end
        // Fold into the quadrant, modulo one turn.
        if (xs >= 0)
            dir = HALF_TURN - dir;
        if (ys >= 0)
            dir = FULL_TURN - dir;
        folded = dir[ANGLE_W-1:0];
        return folded;
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall bursts and the result check
    // ------------------------------------------------------------------

    // Raise out_stall in random bursts; one assignment per edge.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic note_failure(input string what, input logic [ANGLE_W-1:0] want,
                                input logic [ANGLE_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s: expected angle 0x%02h, got 0x%02h", $time, what, want, got);
    endtask

    // Check every output beat against the oldest owed angle. Sample at the
    // edge itself: the values seen here are the ones the handshake used.
    always @(posedge clk)
    begin : result_check
        logic [ANGLE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_angles.size() == 0)
                note_failure("beat with nothing owed", 'x, angle);
            else
            begin
                want = expected_angles.pop_front();
                if (angle !== want)
                    note_failure("angle mismatch", want, angle);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one vector and hold it until accepted. Called at a rising
    // edge; returns at the edge where the beat was taken, with in_valid
    // still high so back-to-back beats need no extra assignment.
    task automatic send_vector(input logic signed [FIELD_W-1:0] x,
                               input logic signed [FIELD_W-1:0] y);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_coord  <= x;
        y_coord  <= y;
        do
            @(posedge clk);
        while (in_stall);
        expected_angles.push_back(predict_angle(x, y));
    endtask

    // Drop valid and hold until every owed angle has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
    endtask

    // Apply a sign to a magnitude in 0..32768.
    function automatic logic signed [FIELD_W-1:0] signed_coord(input int mag, input bit neg);
        logic signed [FIELD_W-1:0] v;
        v = FIELD_W'(neg ? -mag : mag);
        return v;
    endfunction

    // Random sign bit.
    function automatic bit rand_sign();
        bit s;
        s = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners: zero vector, axes, full-scale values including the most
    // negative coordinate, equal magnitudes in all four quadrants, unit
    // steps and extreme ratios.
    task automatic test_directed_corners();
        send_vector(16'sh0000, 16'sh0000);
        send_vector(16'sh7FFF, 16'sh0000);
        send_vector(16'sh8000, 16'sh0000);
        send_vector(16'sh0000, 16'sh7FFF);
        send_vector(16'sh0000, 16'sh8000);
        send_vector(16'sh8000, 16'sh8000);
        send_vector(16'sh7FFF, 16'sh7FFF);
        send_vector(16'sh8000, 16'sh7FFF);
        send_vector(16'sh7FFF, 16'sh8000);
        send_vector(16'sh0005, 16'sh0005);
        send_vector(-16'sh0005, 16'sh0005);
        send_vector(16'sh0005, -16'sh0005);
        send_vector(-16'sh0005, -16'sh0005);
        send_vector(16'sh0001, 16'sh0000);
        send_vector(16'sh0000, 16'sh0001);
        send_vector(16'shFFFF, 16'sh0000);
        send_vector(16'sh0000, 16'shFFFF);
        send_vector(16'shFFFF, 16'shFFFF);
        send_vector(16'sh0001, 16'sh7FFF);
        send_vector(16'sh7FFF, 16'sh0001);
        send_vector(16'sh8000, 16'sh0001);
        send_vector(16'sh0001, 16'sh8000);
        send_vector(16'sh5555, 16'shAAAA);
        send_vector(16'shAAAA, 16'sh5555);
    endtask

    // Full-range vectors: every bit of both fields toggles.
    task automatic test_random_full(input int count);
        repeat (count)
            send_vector(FIELD_W'($urandom_range(0, 16'hFFFF)),
                        FIELD_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // Small vectors, so the quotient sweeps the whole table and zero
    // components turn up often.
    task automatic test_random_small(input int count);
        int span;
        repeat (count)
        begin
            span = $urandom_range(0, 3) == 0 ? 4 : 300;
            send_vector(signed_coord(int'($urandom_range(0, span)), rand_sign()),
                        signed_coord(int'($urandom_range(0, span)), rand_sign()));
        end
    endtask

    // Near the octant boundary: magnitudes equal or a few apart, both
    // branches of the divide and the top of the table.
    task automatic test_near_diagonal(input int count);
        int mag;
        int other;
        repeat (count)
        begin
            mag   = int'($urandom_range(1, 32768));
            other = mag + int'($urandom_range(0, 8)) - 4;
            if (other < 0)
                other = 0;
            if (other > 32768)
                other = 32768;
            if ($urandom_range(0, 1))
                send_vector(signed_coord(mag, rand_sign()),
                            signed_coord(other, rand_sign()));
            else
                send_vector(signed_coord(other, rand_sign()),
                            signed_coord(mag, rand_sign()));
        end
    endtask

    // Stop feeding mid-stream until the pipeline has emptied, then resume.
    task automatic test_drain_pause(input int count);
        test_random_full(count);
        wait_drained();
        test_random_small(count);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        x_coord    = '0;
        y_coord    = '0;
        fail_count = 0;
        gap_odds   = 0;
        stall_odds = 0;

        // Hold reset, then release it on an edge.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners with light idling on both sides.
        gap_odds   = 6;
        stall_odds = 6;
        test_directed_corners();

        gap_odds   = 5;
        stall_odds = 4;
        test_random_full(300);

        // Output backpressure only, so the input queues up behind it.
        gap_odds   = 0;
        stall_odds = 3;
        test_random_small(150);

        gap_odds   = 3;
        stall_odds = 0;
        test_near_diagonal(150);

        gap_odds   = 8;
        stall_odds = 8;
        test_drain_pause(50);

        // Last stretch at full rate: no idling on either side.
        gap_odds   = 0;
        stall_odds = 0;
        test_random_full(100);
        test_near_diagonal(100);

        // Drop valid, let the pipeline empty, then watch for stray beats.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_angles.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
src/tla_pkg.sv
src/tla_front.sv
src/tla_div_stage.sv
src/tla_fold.sv
src/table_atan2_byte_angle_top.sv
bench/tb_top.sv
